[hdl/setq_pkg.sv]
// Package for the sorted expiry timer queue.
// Holds the widths, operation and status codes, state type and memory port structures.
// Used by setq_store and sorted_expiry_timer_queue_core; depends on nothing.
package setq_pkg;

    localparam int HANDLES      = 32;
    localparam int ID_W         = 5;
    localparam int LINK_W       = 6;
    localparam int TIME_W       = 32;
    localparam int CAPACITY_DEF = 32;
    localparam int IN_DATA_W    = 72;
    localparam int OUT_DATA_W   = 8;

    localparam logic [LINK_W-1:0] NIL_LINK = 6'h3F;

    typedef enum logic [1:0] {
        KIND_ADD,
        KIND_ADJUST,
        KIND_DELETE,
        KIND_TICK
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK,
        ST_FULL,
        ST_INACTIVE,
        ST_ACTIVE
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESP,
        S_UNLINK,
        S_START,
        S_WALK,
        S_LINK1,
        S_LINK2,
        S_TICK
    } t_state;

    typedef struct packed {
        logic              en;
        logic [ID_W-1:0]   addr;
        logic [TIME_W-1:0] data;
    } t_time_wr;

    typedef struct packed {
        logic              en;
        logic [ID_W-1:0]   addr;
        logic [LINK_W-1:0] data;
    } t_link_wr;

    typedef struct packed {
        logic [TIME_W-1:0] exp;
        logic [LINK_W-1:0] nxt;
        logic [LINK_W-1:0] prv;
    } t_rd_data;

endpackage

[hdl/setq_store.sv]
// Entry store of the timer queue: expiry, next link and previous link memories.
// One shared read address with registered read data, one write port per memory.
// Depends on setq_pkg.
module setq_store (
    input  logic                     i_clk,
    input  logic [setq_pkg::ID_W-1:0] i_rd_addr,
    output setq_pkg::t_rd_data       o_rd,
    input  setq_pkg::t_time_wr       i_exp_wr,
    input  setq_pkg::t_link_wr       i_nxt_wr,
    input  setq_pkg::t_link_wr       i_prv_wr
);
    import setq_pkg::*;

    logic [TIME_W-1:0] r_exp_mem [HANDLES];
    logic [LINK_W-1:0] r_nxt_mem [HANDLES];
    logic [LINK_W-1:0] r_prv_mem [HANDLES];

    always_ff @(posedge i_clk) begin
        if (i_exp_wr.en) begin
            r_exp_mem[i_exp_wr.addr] <= i_exp_wr.data;
        end
        if (i_nxt_wr.en) begin
            r_nxt_mem[i_nxt_wr.addr] <= i_nxt_wr.data;
        end
        if (i_prv_wr.en) begin
            r_prv_mem[i_prv_wr.addr] <= i_prv_wr.data;
        end
        o_rd.exp <= r_exp_mem[i_rd_addr];
        o_rd.nxt <= r_nxt_mem[i_rd_addr];
        o_rd.prv <= r_prv_mem[i_rd_addr];
    end

endmodule

[hdl/sorted_expiry_timer_queue_core.sv]
// Sorted expiry timer queue: a doubly linked list of timers kept in expiry order.
// Add and adjust walk the list from the head, one entry per cycle through the store's read port,
// to find the insertion point; delete unlinks the entry; a rejected request goes straight to the
// response; a tick pops each expired timer from the head. Requests are taken one at a time, the
// next in the cycle after the last result is loaded; output stalls hold the response states.
// Reset is synchronous and clears state, head, count and active flags; memories are not cleared.
module sorted_expiry_timer_queue_core #(
    parameter int CAPACITY = setq_pkg::CAPACITY_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // timer_id [4:0], expire_time [36:5], now_time [68:37], zero [71:69]
    input  logic [setq_pkg::IN_DATA_W-1:0] i_s_tdata,
    // kind [1:0]
    input  logic [1:0]                     i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // status [1:0], expired_id [6:2], zero [7]
    output logic [setq_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // expired_valid [0]
    output logic                           o_m_tuser,
    output logic                           o_m_tlast
);
    import setq_pkg::*;

    localparam int LIMIT = (CAPACITY < HANDLES) ? CAPACITY : HANDLES;
    localparam int CNT_W = $clog2(LIMIT + 1);

    t_state              r_state, n_state;
    t_kind               r_kind, n_kind;
    t_status             r_status, n_status;
    logic [ID_W-1:0]     r_id, n_id;
    logic [TIME_W-1:0]   r_exp, n_exp;
    logic [TIME_W-1:0]   r_now, n_now;
    logic [LINK_W-1:0]   r_head, n_head;
    logic [LINK_W-1:0]   r_at, n_at;
    logic [LINK_W-1:0]   r_before, n_before;
    logic [HANDLES-1:0]  r_active, n_active;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_pend_valid, n_pend_valid;
    logic [ID_W-1:0]     r_pend_id, n_pend_id;
    logic [ID_W-1:0]     r_ra;

    logic                r_out_valid;
    t_status             r_out_status;
    logic                r_out_xvalid;
    logic [ID_W-1:0]     r_out_id;
    logic                r_out_last;

    t_kind               in_kind;
    logic [ID_W-1:0]     in_id;
    logic [TIME_W-1:0]   in_exp;
    logic [TIME_W-1:0]   in_now;

    logic                accept;
    logic                out_free;
    logic                full;
    logic                walk_stop;
    logic                tick_hit;

    logic [ID_W-1:0]     rd_addr;
    t_rd_data            rd;
    t_time_wr            exp_wr;
    t_link_wr            nxt_wr;
    t_link_wr            prv_wr;

    logic                emit;
    t_status             e_status;
    logic                e_xvalid;
    logic [ID_W-1:0]     e_id;
    logic                e_last;

    assign in_kind = t_kind'(i_s_tuser);
    assign in_id   = i_s_tdata[ID_W-1:0];
    assign in_exp  = i_s_tdata[ID_W +: TIME_W];
    assign in_now  = i_s_tdata[ID_W+TIME_W +: TIME_W];

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign full       = (r_count >= CNT_W'(LIMIT));
    assign walk_stop  = r_at[LINK_W-1] || (rd.exp > r_exp);
    assign tick_hit   = !r_head[LINK_W-1] && (r_now >= rd.exp);

    setq_store u_store (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rd      (rd),
        .i_exp_wr  (exp_wr),
        .i_nxt_wr  (nxt_wr),
        .i_prv_wr  (prv_wr)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (in_kind) inside
                        KIND_ADD: begin
                            n_state = (r_active[in_id] || full) ? S_RESP : S_WALK;
                        end
                        KIND_ADJUST, KIND_DELETE: begin
                            n_state = r_active[in_id] ? S_UNLINK : S_RESP;
                        end
                        default: begin
                            n_state = S_TICK;
                        end
                    endcase
                end
            end
            S_RESP, S_LINK2: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_UNLINK: begin
                n_state = (r_kind == KIND_ADJUST) ? S_START : S_RESP;
            end
            S_START: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                if (walk_stop) begin
                    n_state = S_LINK1;
                end
            end
            S_LINK1: begin
                n_state = S_LINK2;
            end
            S_TICK: begin
                if (!tick_hit && out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_kind       = r_kind;
        n_status     = r_status;
        n_id         = r_id;
        n_exp        = r_exp;
        n_now        = r_now;
        n_head       = r_head;
        n_at         = r_at;
        n_before     = r_before;
        n_active     = r_active;
        n_count      = r_count;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        rd_addr      = r_ra;
        exp_wr       = '0;
        nxt_wr       = '0;
        prv_wr       = '0;
        emit         = 1'b0;
        e_status     = ST_OK;
        e_xvalid     = 1'b0;
        e_id         = '0;
        e_last       = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind       = in_kind;
                    n_id         = in_id;
                    n_exp        = in_exp;
                    n_now        = in_now;
                    n_status     = ST_OK;
                    n_at         = r_head;
                    n_before     = NIL_LINK;
                    n_pend_valid = 1'b0;
                    rd_addr      = r_head[ID_W-1:0];
                    case (in_kind) inside
                        KIND_ADD: begin
                            if (r_active[in_id]) begin
                                n_status = ST_ACTIVE;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_active[in_id] = 1'b1;
                                n_count         = r_count + 1'b1;
                                exp_wr          = '{1'b1, in_id, in_exp};
                            end
                        end
                        KIND_ADJUST, KIND_DELETE: begin
                            rd_addr = in_id;
                            if (!r_active[in_id]) begin
                                n_status = ST_INACTIVE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RESP: begin
                emit     = out_free;
                e_status = r_status;
            end
            S_UNLINK: begin
                if (rd.prv[LINK_W-1]) begin
                    n_head = rd.nxt;
                end else begin
                    nxt_wr = '{1'b1, rd.prv[ID_W-1:0], rd.nxt};
                end
                if (!rd.nxt[LINK_W-1]) begin
                    prv_wr = '{1'b1, rd.nxt[ID_W-1:0], rd.prv};
                end
                if (r_kind == KIND_ADJUST) begin
                    exp_wr = '{1'b1, r_id, r_exp};
                end else begin
                    n_active[r_id] = 1'b0;
                    n_count        = r_count - 1'b1;
                end
            end
            S_START: begin
                rd_addr  = r_head[ID_W-1:0];
                n_at     = r_head;
                n_before = NIL_LINK;
            end
            S_WALK: begin
                if (!walk_stop) begin
                    n_before = r_at;
                    n_at     = rd.nxt;
                    rd_addr  = rd.nxt[ID_W-1:0];
                end
            end
            S_LINK1: begin
                nxt_wr = '{1'b1, r_id, r_at};
                prv_wr = '{1'b1, r_id, r_before};
                if (r_before[LINK_W-1]) begin
                    n_head = {1'b0, r_id};
                end
            end
            S_LINK2: begin
                if (!r_before[LINK_W-1]) begin
                    nxt_wr = '{1'b1, r_before[ID_W-1:0], {1'b0, r_id}};
                end
                if (!r_at[LINK_W-1]) begin
                    prv_wr = '{1'b1, r_at[ID_W-1:0], {1'b0, r_id}};
                end
                emit = out_free;
            end
            S_TICK: begin
                if (tick_hit) begin
                    if (r_pend_valid) begin
                        emit     = out_free;
                        e_xvalid = 1'b1;
                        e_id     = r_pend_id;
                        e_last   = 1'b0;
                    end
                    if (!r_pend_valid || out_free) begin
                        n_head                       = rd.nxt;
                        n_active[r_head[ID_W-1:0]]   = 1'b0;
                        n_count                      = r_count - 1'b1;
                        n_pend_valid                 = 1'b1;
                        n_pend_id                    = r_head[ID_W-1:0];
                        rd_addr                      = rd.nxt[ID_W-1:0];
                        if (!rd.nxt[LINK_W-1]) begin
                            prv_wr = '{1'b1, rd.nxt[ID_W-1:0], NIL_LINK};
                        end
                    end
                end else begin
                    emit     = out_free;
                    e_xvalid = r_pend_valid;
                    e_id     = r_pend_valid ? r_pend_id : '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= NIL_LINK;
            r_active     <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_active     <= n_active;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_status  <= n_status;
        r_id      <= n_id;
        r_exp     <= n_exp;
        r_now     <= n_now;
        r_at      <= n_at;
        r_before  <= n_before;
        r_pend_id <= n_pend_id;
        r_ra      <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_status <= e_status;
            r_out_xvalid <= e_xvalid;
            r_out_id     <= e_id;
            r_out_last   <= e_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_id, r_out_status};
    assign o_m_tuser  = r_out_xvalid;
    assign o_m_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(r_active)))
        else $error("Active count differs from the number of active flags.");

    a_head_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_head[LINK_W-1] == (r_count == '0)))
        else $error("List head and active count disagree on an empty queue.");

    a_pop_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK && tick_hit) |-> r_active[r_head[ID_W-1:0]])
        else $error("Tick pops an entry that is not active.");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("Result loaded while the output register still holds one.");
`endif

endmodule
